/* src/hsa_pkg.sv */
// Shared types and constants for the handle slot allocator.
`default_nettype none

package hsa_pkg;

  localparam int HARBOR_W   = 8;
  localparam int HANDLE_W   = 32;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_RETIRE   = 2'd1,
    OP_LOOKUP   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
  } in_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    logic                ok;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_t;

endpackage

`default_nettype wire

/* src/hsa_fifo.sv */
// Small register-based queue used between the allocator stages and for the responses.
`default_nettype none

module hsa_fifo
  import hsa_pkg::*;
#(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* src/hsa_front.sv */
// Front stage: takes requests and works out the slot index of the given handle.
`default_nettype none

module hsa_front
  import hsa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clearing,
  input  wire logic                       in_push,
  input  wire in_req_t                    in_req,
  output logic                            in_full,
  input  wire logic                       q_full,
  output logic                            q_push,
  output in_req_t                         q_req,
  output logic [$clog2(SLOTS)-1:0]        q_slot
);

  localparam int            SW         = $clog2(SLOTS);
  localparam bit            IS_POW2    = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int            CW         = 2;
  localparam int            RW         = HANDLE_W + 1;
  localparam int            AW         = HANDLE_W + RW;
  localparam logic [63:0]   RECIP_FULL = ((64'd1 << (HANDLE_W + SW)) + 64'(SLOTS - 1))
                                         / 64'(SLOTS);
  localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];
  localparam logic [SW-1:0] SLOT_DIV   = SW'(SLOTS);

  logic                fr_valid_r, fr_valid_nxt;
  in_req_t             fr_req_r, fr_req_nxt;
  logic [AW-1:0]       fr_acc_r, fr_acc_nxt;
  logic [SW-1:0]       fr_rem_r, fr_rem_nxt;
  logic [CW-1:0]       fr_cnt_r, fr_cnt_nxt;
  logic                fr_done, accept;
  logic [AW-1:0]       prod;
  logic [SW-1:0]       quot_lo;
  logic [SW-1:0]       rem_step;

  assign fr_done = (fr_cnt_r == '0);
  assign q_push  = fr_valid_r && fr_done && !q_full;
  assign in_full = clearing || (fr_valid_r && !q_push);
  assign accept  = in_push && !in_full;
  assign q_req   = fr_req_r;
  assign q_slot  = fr_rem_r;

  // The remainder by SLOTS comes from a multiply by its rounded-up reciprocal.
  assign prod     = AW'(fr_req_r.handle) * AW'(RECIP);
  assign quot_lo  = fr_acc_r[HANDLE_W+SW +: SW];
  assign rem_step = fr_req_r.handle[SW-1:0] - SW'(quot_lo * SLOT_DIV);

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_req_nxt   = fr_req_r;
    fr_acc_nxt   = fr_acc_r;
    fr_rem_nxt   = fr_rem_r;
    fr_cnt_nxt   = fr_cnt_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
      fr_req_nxt   = in_req;
      if (IS_POW2) begin
        fr_rem_nxt = in_req.handle[SW-1:0];
        fr_cnt_nxt = '0;
      end else begin
        fr_rem_nxt = '0;
        fr_cnt_nxt = CW'(2);
      end
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end else if (fr_valid_r && !fr_done) begin
      fr_acc_nxt = prod;
      fr_rem_nxt = rem_step;
      fr_cnt_nxt = fr_cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
      fr_cnt_r   <= '0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
      fr_cnt_r   <= fr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_req_r <= fr_req_nxt;
    fr_acc_r <= fr_acc_nxt;
    fr_rem_r <= fr_rem_nxt;
  end

endmodule

`default_nettype wire

/* src/hsa_back.sv */
// Back stage: slot table, rolling handle scan, retire and lookup.
`default_nettype none

module hsa_back
  import hsa_pkg::*;
#(
  parameter int SLOTS       = 256,
  parameter int HANDLE_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [HARBOR_W-1:0]        harbor,
  output logic                            clearing,
  input  wire logic                       cmd_empty,
  output logic                            cmd_pop,
  input  wire in_req_t                    cmd_req,
  input  wire logic [$clog2(SLOTS)-1:0]   cmd_slot,
  input  wire logic                       rsp_full,
  output logic                            rsp_push,
  output out_rsp_t                        rsp
);

  localparam int                  SW       = $clog2(SLOTS);
  localparam int                  HB       = HANDLE_BITS;
  localparam logic [HB-1:0]       IDX_MASK = {HB{1'b1}};
  localparam logic [SW-1:0]       LAST     = SW'(SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  op_t                 cmd_op_r, cmd_op_nxt;
  logic [HANDLE_W-1:0] cmd_handle_r, cmd_handle_nxt;
  logic [SW-1:0]       cmd_slot_r, cmd_slot_nxt;
  logic [HB-1:0]       next_cand_r, next_cand_nxt;
  logic [SW-1:0]       next_slot_r, next_slot_nxt;
  logic [HB-1:0]       pc_r, pc_nxt, ac_r, ac_nxt;
  logic [SW-1:0]       ps_r, ps_nxt, as_r, as_nxt;
  logic [SW-1:0]       pn_r, pn_nxt;

  logic                valid_mem [SLOTS];
  logic [HANDLE_W-1:0] handle_mem [SLOTS];
  logic                rd_valid_r;
  logic [HANDLE_W-1:0] rd_handle_r;
  logic [SW-1:0]       rd_addr;
  logic                v_we, v_wdata, h_we;
  logic [SW-1:0]       w_addr;
  logic [HANDLE_W-1:0] full_handle;
  logic                match;
  logic                start;

  function automatic logic [HB-1:0] step_cand(input logic [HB-1:0] c);
    return (c == IDX_MASK) ? HB'(1) : c + HB'(1);
  endfunction

  function automatic logic [SW-1:0] step_slot(input logic [HB-1:0] c,
                                              input logic [SW-1:0] s);
    logic [SW-1:0] n;
    n = (s == LAST) ? '0 : s + SW'(1);
    return (c == IDX_MASK) ? SW'(1) : n;
  endfunction

  assign full_handle = {harbor, (HANDLE_W-HARBOR_W)'(pc_r)};
  assign match       = rd_valid_r && (rd_handle_r == cmd_handle_r);
  assign start       = !cmd_empty && !rsp_full;
  assign clearing    = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_req.op)
            OP_REGISTER: state_nxt = ST_SCAN;
            OP_RETIRE:   state_nxt = ST_CHECK;
            OP_LOOKUP:   state_nxt = ST_CHECK;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!rd_valid_r || (pn_r == LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    cmd_op_nxt     = cmd_op_r;
    cmd_handle_nxt = cmd_handle_r;
    cmd_slot_nxt   = cmd_slot_r;
    next_cand_nxt  = next_cand_r;
    next_slot_nxt  = next_slot_r;
    pc_nxt         = pc_r;
    ps_nxt         = ps_r;
    pn_nxt         = pn_r;
    ac_nxt         = ac_r;
    as_nxt         = as_r;
    rd_addr        = as_r;
    v_we           = 1'b0;
    v_wdata        = 1'b0;
    h_we           = 1'b0;
    w_addr         = ps_r;
    cmd_pop        = 1'b0;
    rsp_push       = 1'b0;
    rsp            = '{result_handle: cmd_handle_r, ok: 1'b0};
    case (state_r)
      ST_CLEAR: begin
        v_we    = 1'b1;
        w_addr  = clr_r;
        clr_nxt = clr_r + SW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          cmd_pop        = 1'b1;
          cmd_op_nxt     = cmd_req.op;
          cmd_handle_nxt = cmd_req.handle;
          cmd_slot_nxt   = cmd_slot;
          case (cmd_req.op)
            OP_REGISTER: begin
              rd_addr = next_slot_r;
              pc_nxt  = next_cand_r;
              ps_nxt  = next_slot_r;
              pn_nxt  = '0;
              ac_nxt  = step_cand(next_cand_r);
              as_nxt  = step_slot(next_cand_r, next_slot_r);
            end
            OP_RETIRE: rd_addr = cmd_slot;
            OP_LOOKUP: rd_addr = cmd_slot;
            default: begin
              rsp_push = 1'b1;
              rsp      = '{result_handle: cmd_req.handle, ok: 1'b0};
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!rd_valid_r) begin
          v_we          = 1'b1;
          v_wdata       = 1'b1;
          h_we          = 1'b1;
          next_cand_nxt = step_cand(pc_r);
          next_slot_nxt = step_slot(pc_r, ps_r);
          rsp_push      = 1'b1;
          rsp           = '{result_handle: full_handle, ok: 1'b1};
        end else if (pn_r == LAST) begin
          rsp_push = 1'b1;
          rsp      = '{result_handle: '0, ok: 1'b0};
        end else begin
          rd_addr = as_r;
          pc_nxt  = ac_r;
          ps_nxt  = as_r;
          pn_nxt  = pn_r + SW'(1);
          ac_nxt  = step_cand(ac_r);
          as_nxt  = step_slot(ac_r, as_r);
        end
      end
      ST_CHECK: begin
        w_addr   = cmd_slot_r;
        v_we     = (cmd_op_r == OP_RETIRE) && match;
        rsp_push = 1'b1;
        rsp      = '{result_handle: cmd_handle_r, ok: match};
      end
      default: begin
        rsp = '{result_handle: cmd_handle_r, ok: 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      next_cand_r <= HB'(1);
      next_slot_r <= SW'(1);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_cand_r <= next_cand_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_op_r     <= cmd_op_nxt;
    cmd_handle_r <= cmd_handle_nxt;
    cmd_slot_r   <= cmd_slot_nxt;
    pc_r         <= pc_nxt;
    ps_r         <= ps_nxt;
    pn_r         <= pn_nxt;
    ac_r         <= ac_nxt;
    as_r         <= as_nxt;
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      valid_mem[w_addr] <= v_wdata;
    end
    rd_valid_r <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      handle_mem[w_addr] <= full_handle;
    end
    rd_handle_r <= handle_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/handle_slot_allocator.sv */
// Top level of the handle slot allocator.
// Retire and lookup requests pass the front register, the middle queue, the table engine's
// idle and check states and the response queue, with reciprocal steps in the front stage
// when SLOTS is not a power of two. A register request probes the table from the idle and
// scan states: 1 to SLOTS probes until a free slot turns up, one per cycle through the slot
// memories' read port. After reset the valid store is cleared slot by slot, in_full held high.
`default_nettype none

module handle_slot_allocator
  import hsa_pkg::*;
#(
  parameter int SLOTS       = 256,
  parameter int HANDLE_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire in_req_t             in_req,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output out_rsp_t                 out_rsp,
  input  wire logic                cfg_we,
  input  wire logic [HARBOR_W-1:0] cfg_wdata
);

  localparam int SW    = $clog2(SLOTS);
  localparam int MID_W = $bits(in_req_t) + SW;
  localparam int RSP_W = $bits(out_rsp_t);

  logic [HARBOR_W-1:0] harbor_r;
  logic                clearing;
  logic                fq_full, fq_push, fq_empty, fq_pop;
  in_req_t             fq_req, bq_req;
  logic [SW-1:0]       fq_slot, bq_slot;
  logic [MID_W-1:0]    mid_rdata;
  logic                rq_full, rq_push;
  out_rsp_t            rq_rsp;
  logic [RSP_W-1:0]    rsp_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      harbor_r <= '0;
    end else if (cfg_we) begin
      harbor_r <= cfg_wdata;
    end
  end

  hsa_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .in_push  (in_push),
    .in_req   (in_req),
    .in_full  (in_full),
    .q_full   (fq_full),
    .q_push   (fq_push),
    .q_req    (fq_req),
    .q_slot   (fq_slot)
  );

  hsa_fifo #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_req, fq_slot}),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (mid_rdata),
    .empty (fq_empty)
  );

  assign bq_req  = in_req_t'(mid_rdata[MID_W-1:SW]);
  assign bq_slot = mid_rdata[SW-1:0];

  hsa_back #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .harbor    (harbor_r),
    .clearing  (clearing),
    .cmd_empty (fq_empty),
    .cmd_pop   (fq_pop),
    .cmd_req   (bq_req),
    .cmd_slot  (bq_slot),
    .rsp_full  (rq_full),
    .rsp_push  (rq_push),
    .rsp       (rq_rsp)
  );

  hsa_fifo #(
    .WIDTH (RSP_W),
    .DEPTH (2)
  ) u_rsp_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_rsp),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rsp_rdata),
    .empty (out_empty)
  );

  assign out_rsp = out_rsp_t'(rsp_rdata);

endmodule

`default_nettype wire

/* dv/tb_handle_slot_allocator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the handle slot allocator with a table predictor and random traffic.
module tb_handle_slot_allocator;
  import hsa_pkg::*;

  localparam int SLOTS       = 256;
  localparam int HANDLE_BITS = 24;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam logic [24:0] IDX_MASK = (25'd1 << HANDLE_BITS) - 25'd1;
  localparam int STALL_LIMIT = 5000;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  in_req_t             in_req;
  logic                in_full;
  logic                out_empty;
  logic                out_pop = 1'b0;
  out_rsp_t            out_rsp;
  logic                cfg_we;
  logic [HARBOR_W-1:0] cfg_wdata;

  logic                slot_live [SLOTS];
  logic                slot_written [SLOTS];
  logic [HANDLE_W-1:0] slot_owner [SLOTS];
  logic [24:0]         next_cand;
  logic [HARBOR_W-1:0] harbor;
  int                  live_count;

  out_rsp_t            awaited_rsp_q[$];
  int                  error_count = 0;
  int                  pop_stall = 0;
  int                  quiet_cycles = 0;
  bit                  no_gaps = 1'b0;

  handle_slot_allocator #(
    .SLOTS      (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_req   (in_req),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int slot_of(logic [HANDLE_W-1:0] h);
    return int'(h % SLOTS);
  endfunction

  function automatic out_rsp_t apply_to_table(in_req_t r);
    out_rsp_t    rsp;
    logic [24:0] cand;
    int          s;
    int          i;
    bit          done;
    rsp.result_handle = r.handle;
    rsp.ok = 1'b0;
    done = 1'b0;
    case (r.op)
      OP_REGISTER: begin
        rsp.result_handle = '0;
        cand = next_cand;
        for (i = 0; i < SLOTS && !done; i++) begin
          if (cand > IDX_MASK) cand = 25'd1;
          s = slot_of(32'(cand));
          if (!slot_live[s]) begin
            slot_live[s] = 1'b1;
            slot_written[s] = 1'b1;
            slot_owner[s] = {harbor, 24'd0} | 32'(cand);
            next_cand = cand + 25'd1;
            live_count++;
            rsp.result_handle = slot_owner[s];
            rsp.ok = 1'b1;
            done = 1'b1;
          end else begin
            cand = cand + 25'd1;
          end
        end
      end
      OP_RETIRE: begin
        s = slot_of(r.handle);
        if (slot_live[s] && slot_owner[s] == r.handle) begin
          slot_live[s] = 1'b0;
          live_count--;
          rsp.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        s = slot_of(r.handle);
        if (slot_live[s] && slot_owner[s] == r.handle) rsp.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_live();
    int                  base;
    int                  k;
    logic [HANDLE_W-1:0] h;
    base = $urandom_range(0, SLOTS - 1);
    h = '0;
    for (k = SLOTS - 1; k >= 0; k--) begin
      if (slot_live[(base + k) % SLOTS]) h = slot_owner[(base + k) % SLOTS];
    end
    return h;
  endfunction

  // Slot contents are undefined until first written, so stray handles are steered to a written slot.
  function automatic logic [HANDLE_W-1:0] aim_at_written(logic [HANDLE_W-1:0] h);
    int base;
    int k;
    int s;
    if (slot_written[slot_of(h)]) return h;
    base = $urandom_range(0, SLOTS - 1);
    s = 0;
    for (k = SLOTS - 1; k >= 0; k--) begin
      if (slot_written[(base + k) % SLOTS]) s = (base + k) % SLOTS;
    end
    return h - HANDLE_W'(slot_of(h)) + HANDLE_W'(s);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_req_t mk_req(op_t op, logic [HANDLE_W-1:0] h);
    in_req_t r;
    r.op = op;
    r.handle = h;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [HANDLE_W-1:0] got,
                                 logic [HANDLE_W-1:0] want);
    $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_rsp(out_rsp_t got);
    out_rsp_t want;
    if (awaited_rsp_q.size() == 0) begin
      report_mismatch("response with no request outstanding", got.result_handle, '0);
    end else begin
      want = awaited_rsp_q.pop_front();
      if (got.result_handle !== want.result_handle)
        report_mismatch("result_handle", got.result_handle, want.result_handle);
      if (got.ok !== want.ok)
        report_mismatch("ok", HANDLE_W'(got.ok), HANDLE_W'(want.ok));
    end
  endtask

  task automatic send_req(input in_req_t r, output out_rsp_t pred);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred = apply_to_table(r);
    awaited_rsp_q.push_back(pred);
  endtask

  task automatic drain_and_settle();
    in_push <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_harbor(logic [HARBOR_W-1:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    harbor = v;
  endtask

  task automatic test_basic_ops();
    out_rsp_t h1;
    out_rsp_t h2;
    out_rsp_t h3;
    out_rsp_t rsp;
    set_harbor(8'h5A);
    send_req(mk_req(OP_REGISTER, 32'hFFFF_FFFF), h1);
    send_req(mk_req(OP_REGISTER, 32'h0000_0000), h2);
    send_req(mk_req(OP_REGISTER, 32'h1234_5678), h3);
    send_req(mk_req(OP_LOOKUP, h1.result_handle), rsp);
    send_req(mk_req(OP_LOOKUP, h1.result_handle ^ 32'h8000_0000), rsp);
    send_req(mk_req(OP_LOOKUP, h1.result_handle ^ 32'h0000_0100), rsp);
    send_req(mk_req(OP_RETIRE, h2.result_handle ^ 32'h0100_0000), rsp);
    send_req(mk_req(OP_RETIRE, h2.result_handle), rsp);
    send_req(mk_req(OP_RETIRE, h2.result_handle), rsp);
    send_req(mk_req(OP_LOOKUP, h2.result_handle), rsp);
    send_req(mk_req(op_t'(2'd3), h3.result_handle), rsp);
    send_req(mk_req(OP_LOOKUP, h3.result_handle), rsp);
    send_req(mk_req(OP_REGISTER, 32'h0000_0000), rsp);
    send_req(mk_req(OP_REGISTER, 32'h0000_0000), rsp);
  endtask

  task automatic test_table_full();
    out_rsp_t rsp;
    int       target;
    set_harbor(8'hFF);
    while (live_count < SLOTS) send_req(mk_req(OP_REGISTER, $urandom()), rsp);
    send_req(mk_req(OP_REGISTER, 32'h0000_0000), rsp);
    send_req(mk_req(OP_LOOKUP, 32'hFFFF_FFFF), rsp);
    send_req(mk_req(OP_RETIRE, 32'hFFFF_FFFF), rsp);
    send_req(mk_req(OP_LOOKUP, 32'h0000_0000), rsp);
    send_req(mk_req(OP_RETIRE, 32'h0000_0000), rsp);
    send_req(mk_req(op_t'(2'd3), 32'hFFFF_FFFF), rsp);
    target = $urandom_range(80, 120);
    while (live_count > target) send_req(mk_req(OP_RETIRE, pick_live()), rsp);
  endtask

  task automatic test_random_traffic(logic [HARBOR_W-1:0] harbor_val, int count);
    out_rsp_t            rsp;
    in_req_t             r;
    int                  n;
    int                  pick;
    int                  bitpos;
    logic [HANDLE_W-1:0] h;
    set_harbor(harbor_val);
    for (n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (live_count == 0) pick = 0;
      else if (live_count > 200 && pick < 35) pick = 40;
      if (pick < 35 || pick >= 97) begin
        r = mk_req(OP_REGISTER, $urandom());
      end else if (pick < 55) begin
        r = mk_req(OP_RETIRE, pick_live());
      end else if (pick < 70) begin
        r = mk_req(OP_LOOKUP, pick_live());
      end else if (pick < 80) begin
        r = mk_req(OP_LOOKUP, aim_at_written($urandom()));
      end else if (pick < 87) begin
        r = mk_req(OP_RETIRE, aim_at_written($urandom()));
      end else if (pick < 93) begin
        h = pick_live();
        bitpos = $urandom_range(SLOT_BITS, HANDLE_W - 1);
        h[bitpos] = ~h[bitpos];
        if ($urandom_range(0, 1) == 0) r = mk_req(OP_RETIRE, h);
        else r = mk_req(OP_LOOKUP, h);
      end else begin
        r = mk_req(op_t'(2'd3), aim_at_written($urandom()));
      end
      send_req(r, rsp);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_stall = 0;
    end else begin
      if (out_pop && !out_empty) begin
        check_rsp(out_rsp);
        pop_stall = pick_gap();
      end else if (pop_stall > 0) begin
        pop_stall--;
      end
      out_pop <= (pop_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    in_push <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    live_count = 0;
    next_cand = 25'd1;
    harbor = '0;
    for (i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_written[i] = 1'b0;
      slot_owner[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (in_full) @(posedge clk);
    test_basic_ops();
    test_table_full();
    test_random_traffic(8'h00, 270);
    test_random_traffic(8'hFF, 270);
    test_random_traffic(HARBOR_W'($urandom()), 270);
    test_random_traffic(HARBOR_W'($urandom()), 260);
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
